[rtl/bxd_pkg.sv]
package bxd_pkg;

	localparam int CHANNELS    = 4;
	localparam int PIX_W       = 8;
	localparam int COORD_W     = 11;
	localparam int ROW_LIMIT   = 2048;
	localparam int ROW_W       = 11;
	localparam int ROW_CNT_W   = 12;
	localparam int SIZE_W      = 12;
	localparam int FACTOR_W    = 5;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;

	localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 12'd480;
	localparam logic [FACTOR_W-1:0] RST_BLOCK_WIDTH  = 5'd2;
	localparam logic [FACTOR_W-1:0] RST_BLOCK_HEIGHT = 5'd2;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_red;
		logic [PIX_W-1:0] pixel_green;
		logic [PIX_W-1:0] pixel_blue;
		logic [PIX_W-1:0] pixel_alpha;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0]   mean_red;
		logic [PIX_W-1:0]   mean_green;
		logic [PIX_W-1:0]   mean_blue;
		logic [PIX_W-1:0]   mean_alpha;
		logic [COORD_W-1:0] out_column;
		logic [COORD_W-1:0] out_row;
		logic               frame_done;
	} mean_t;

endpackage

[rtl/bxd_channels.sv]
interface pixel_ch;
	import bxd_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mean_ch;
	import bxd_pkg::*;

	logic  valid;
	logic  ready;
	mean_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/box_average_downscaler.sv]
// Channel   Direction  Handshake              Payload
// pixel     in         pixel.valid/ready      pixel_t: one RGBA8 raster pixel
// mean      out        mean.valid/ready       mean_t: block means, position, frame end
// cfg       in         cfg_write_en           cfg_index selects, cfg_data carries value
//
// Throughput is one pixel item per clock while pixel.ready is high. The memory read is
// issued at the accepting edge; the result then goes through add and write back,
// multiply and queue write before mean.valid can rise.
// After reset and after every write to a listed register the reciprocal unit runs with
// pixel.ready low; the row-sum memory needs no clear.
// An eight-entry output queue absorbs stalls on the mean side; besides the reciprocal unit,
// pixel.ready drops only when the queue together with results still in flight could overflow.

module box_average_downscaler #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_FACTOR = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [bxd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bxd_pkg::CFG_DATA_W-1:0]   cfg_data,
	pixel_ch.sink                            pixel,
	mean_ch.source                           mean
);
	import bxd_pkg::*;

	// Widths that follow from the size limits.
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int W_W        = $clog2(MAX_WIDTH + 1);
	localparam int FB         = $clog2(MAX_FACTOR);
	localparam int BF_W       = $clog2(MAX_FACTOR + 1);
	localparam int AREA_W     = 2 * BF_W;
	localparam int SUM_W      = PIX_W + 2 * FB;
	localparam int MEM_W      = CHANNELS * SUM_W;
	localparam int SHIFT      = SUM_W + 2 * FB;
	localparam int RECIP_W    = SHIFT + 1;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int DCNT_W     = $clog2(RECIP_W + 1);
	localparam int CB_W       = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
	localparam int RB_W       = $clog2(ROW_LIMIT + 2 * MAX_FACTOR + 1);
	localparam int FIFO_DEPTH = 8;
	localparam int FP_W       = $clog2(FIFO_DEPTH);
	localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

	// ------------------------------------------------------------------
	// Configuration registers. A write to a listed register restarts the
	// frame and recomputes the reciprocal of the block area.
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0]   img_w_q, img_h_q;
	logic [FACTOR_W-1:0] blk_w_q, blk_h_q;
	logic                cfg_hit;

	always_comb begin
		unique case (cfg_index) inside
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
			REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT: cfg_hit = cfg_write_en;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= RST_IMAGE_WIDTH;
			img_h_q <= RST_IMAGE_HEIGHT;
			blk_w_q <= RST_BLOCK_WIDTH;
			blk_h_q <= RST_BLOCK_HEIGHT;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
				REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
				REG_BLOCK_WIDTH:  blk_w_q <= FACTOR_W'(cfg_data);
				REG_BLOCK_HEIGHT: blk_h_q <= FACTOR_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// Register values clamped into their legal ranges: zero acts as one,
	// anything above the limit acts as the limit.
	logic [W_W-1:0]       w_eff;
	logic [ROW_CNT_W-1:0] h_eff;
	logic [BF_W-1:0]      bw_eff, bh_eff;
	logic [AREA_W-1:0]    area_cur;

	always_comb begin
		w_eff = (img_w_q == '0) ? W_W'(1) :
			(int'(img_w_q) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(img_w_q);
		h_eff = (img_h_q == '0) ? ROW_CNT_W'(1) :
			(int'(img_h_q) > ROW_LIMIT) ? ROW_CNT_W'(ROW_LIMIT) : ROW_CNT_W'(img_h_q);
		bw_eff = (blk_w_q == '0) ? BF_W'(1) :
			(int'(blk_w_q) > MAX_FACTOR) ? BF_W'(MAX_FACTOR) : BF_W'(blk_w_q);
		bh_eff = (blk_h_q == '0) ? BF_W'(1) :
			(int'(blk_h_q) > MAX_FACTOR) ? BF_W'(MAX_FACTOR) : BF_W'(blk_h_q);
		area_cur = AREA_W'(bw_eff) * AREA_W'(bh_eff);
	end

	// ------------------------------------------------------------------
	// Reciprocal unit. Computes ceil(2^SHIFT / area) one quotient bit per
	// cycle by restoring division. With SHIFT = SUM_W + log2 of the largest
	// area, (sum * recip) >> SHIFT equals sum / area for every block sum.
	// ------------------------------------------------------------------
	logic                div_go_q, div_busy_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic [AREA_W-1:0]   area_q, rem_q, rem_n;
	logic [RECIP_W-1:0]  recip_q, quo_n, dividend;
	logic [AREA_W:0]     trial;
	logic                trial_ge;

	always_comb begin
		dividend = {1'b1, SHIFT'(0)} + RECIP_W'(area_cur) - RECIP_W'(1);
		trial    = {rem_q, recip_q[RECIP_W-1]};
		trial_ge = trial >= {1'b0, area_q};
		rem_n    = trial_ge ? AREA_W'(trial - {1'b0, area_q}) : AREA_W'(trial);
		quo_n    = {recip_q[RECIP_W-2:0], trial_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q   <= 1'b1;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cfg_hit) begin
			div_go_q   <= 1'b1;
			div_busy_q <= 1'b0;
		end else if (div_go_q) begin
			div_go_q   <= 1'b0;
			div_busy_q <= 1'b1;
			div_cnt_q  <= DCNT_W'(RECIP_W);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
			if (div_cnt_q == DCNT_W'(1))
				div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go_q) begin
			area_q  <= area_cur;
			rem_q   <= '0;
			recip_q <= dividend;
		end else if (div_busy_q) begin
			rem_q   <= rem_n;
			recip_q <= quo_n;
		end
	end

	// ------------------------------------------------------------------
	// Raster position. col_base_q and row_base_q hold the first input
	// column and row of the current block, so the block fits inside the
	// image exactly when base + factor does not pass the image size. This
	// replaces the divisions by the factors.
	// ------------------------------------------------------------------
	logic [COL_W-1:0]   in_col_q, oc_q;
	logic [ROW_W-1:0]   in_row_q, orow_q;
	logic [FB-1:0]      cib_q, rib_q;
	logic [CB_W-1:0]    col_base_q;
	logic [RB_W-1:0]    row_base_q;

	logic [COL_W:0]     col_inc;
	logic [ROW_W:0]     row_inc;
	logic [FB:0]        cib_inc, rib_inc;
	logic               row_end, frame_end, cib_wrap, rib_wrap;
	logic               col_ok, row_ok, col_last, row_last;
	logic               active_s0, first_s0, emit_s0, done_s0;
	logic               accept;

	always_comb begin
		col_inc   = (COL_W+1)'(in_col_q) + (COL_W+1)'(1);
		row_inc   = (ROW_W+1)'(in_row_q) + (ROW_W+1)'(1);
		cib_inc   = (FB+1)'(cib_q) + (FB+1)'(1);
		rib_inc   = (FB+1)'(rib_q) + (FB+1)'(1);
		row_end   = col_inc >= (COL_W+1)'(w_eff);
		frame_end = row_inc >= (ROW_W+1)'(h_eff);
		cib_wrap  = cib_inc >= (FB+1)'(bw_eff);
		rib_wrap  = rib_inc >= (FB+1)'(bh_eff);

		col_ok   = (col_base_q + CB_W'(bw_eff)) <= CB_W'(w_eff);
		col_last = (col_base_q + CB_W'({bw_eff, 1'b0})) > CB_W'(w_eff);
		row_ok   = (row_base_q + RB_W'(bh_eff)) <= RB_W'(h_eff);
		row_last = (row_base_q + RB_W'({bh_eff, 1'b0})) > RB_W'(h_eff);

		// Pixels in leftover columns or rows are consumed and dropped.
		active_s0 = col_ok && row_ok;
		first_s0  = (cib_q == '0) && (rib_q == '0);
		emit_s0   = active_s0 && cib_wrap && rib_wrap;
		done_s0   = col_last && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			cib_q      <= '0;
			rib_q      <= '0;
			oc_q       <= '0;
			orow_q     <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
		end else if (cfg_hit) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			cib_q      <= '0;
			rib_q      <= '0;
			oc_q       <= '0;
			orow_q     <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				in_col_q   <= '0;
				cib_q      <= '0;
				oc_q       <= '0;
				col_base_q <= '0;
				if (frame_end) begin
					in_row_q   <= '0;
					rib_q      <= '0;
					orow_q     <= '0;
					row_base_q <= '0;
				end else begin
					in_row_q <= ROW_W'(row_inc);
					if (rib_wrap) begin
						rib_q      <= '0;
						orow_q     <= orow_q + ROW_W'(1);
						row_base_q <= row_base_q + RB_W'(bh_eff);
					end else begin
						rib_q <= FB'(rib_inc);
					end
				end
			end else begin
				in_col_q <= COL_W'(col_inc);
				if (cib_wrap) begin
					cib_q      <= '0;
					oc_q       <= oc_q + COL_W'(1);
					col_base_q <= col_base_q + CB_W'(bw_eff);
				end else begin
					cib_q <= FB'(cib_inc);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: row-sum memory, one word of four channel sums per output
	// column. The read issued at accept is registered into rd_s1; the write
	// from the item just ahead lands on the same edge, so its data is
	// forwarded when the columns match.
	// ------------------------------------------------------------------
	logic [MEM_W-1:0] sum_mem [MAX_WIDTH];

	logic [CHANNELS-1:0][PIX_W-1:0] px_s0, px_s1;
	logic                 v_s1, emit_s1, first_s1, done_s1;
	logic [COL_W-1:0]     addr_s1;
	logic [ROW_W-1:0]     orow_s1;
	logic [MEM_W-1:0]     rd_s1, base_s1, sum_s1;
	logic                 wr_v_q;
	logic [COL_W-1:0]     wr_addr_q;
	logic [MEM_W-1:0]     wr_data_q;

	assign px_s0 = {pixel.data.pixel_alpha, pixel.data.pixel_blue,
		pixel.data.pixel_green, pixel.data.pixel_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			wr_v_q  <= 1'b0;
		end else begin
			v_s1    <= accept && active_s0;
			emit_s1 <= accept && emit_s0;
			wr_v_q  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1    <= sum_mem[oc_q];
			addr_s1  <= oc_q;
			px_s1    <= px_s0;
			first_s1 <= first_s0;
			done_s1  <= done_s0;
			orow_s1  <= orow_q;
		end
		if (v_s1)
			sum_mem[addr_s1] <= sum_s1;
		wr_addr_q <= addr_s1;
		wr_data_q <= sum_s1;
	end

	always_comb begin
		base_s1 = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_s1;
		for (int c = 0; c < CHANNELS; c++) begin
			sum_s1[c*SUM_W +: SUM_W] = first_s1 ? SUM_W'(px_s1[c]) :
				base_s1[c*SUM_W +: SUM_W] + SUM_W'(px_s1[c]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 holds the finished block sums, stage 3 their products with
	// the reciprocal; the mean is the byte above SHIFT.
	// ------------------------------------------------------------------
	logic                v_s2, v_s3, done_s2, done_s3;
	logic [MEM_W-1:0]    sum_s2;
	logic [COL_W-1:0]    oc_s2, oc_s3;
	logic [ROW_W-1:0]    orow_s2, orow_s3;
	logic [CHANNELS-1:0][PROD_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2  <= sum_s1;
		oc_s2   <= addr_s1;
		orow_s2 <= orow_s1;
		done_s2 <= done_s1;
		for (int c = 0; c < CHANNELS; c++) begin
			prod_s3[c] <= PROD_W'(sum_s2[c*SUM_W +: SUM_W]) * PROD_W'(recip_q);
		end
		oc_s3   <= oc_s2;
		orow_s3 <= orow_s2;
		done_s3 <= done_s2;
	end

	// ------------------------------------------------------------------
	// Output queue. Input is throttled on credit: queued results plus
	// results still in the pipeline never exceed the queue depth.
	// ------------------------------------------------------------------
	mean_t              fifo_mem [FIFO_DEPTH];
	mean_t              push_word;
	logic [FP_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FC_W-1:0]    fifo_cnt_q;
	logic [FC_W:0]      credit;
	logic               pop;

	always_comb begin
		push_word.mean_red   = prod_s3[0][SHIFT +: PIX_W];
		push_word.mean_green = prod_s3[1][SHIFT +: PIX_W];
		push_word.mean_blue  = prod_s3[2][SHIFT +: PIX_W];
		push_word.mean_alpha = prod_s3[3][SHIFT +: PIX_W];
		push_word.out_column = COORD_W'(oc_s3);
		push_word.out_row    = COORD_W'(orow_s3);
		push_word.frame_done = done_s3;
	end

	assign pop    = mean.valid && mean.ready;
	assign credit = (FC_W+1)'(fifo_cnt_q) + (FC_W+1)'(v_s1 && emit_s1)
		+ (FC_W+1)'(v_s2) + (FC_W+1)'(v_s3);

	assign pixel.ready = !div_go_q && !div_busy_q && (credit < (FC_W+1)'(FIFO_DEPTH));
	assign accept      = pixel.valid && pixel.ready;

	assign mean.valid = fifo_cnt_q != '0;
	assign mean.data  = fifo_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (v_s3)
				wr_ptr_q <= wr_ptr_q + FP_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FP_W'(1);
			if (v_s3 && !pop)
				fifo_cnt_q <= fifo_cnt_q + FC_W'(1);
			else if (!v_s3 && pop)
				fifo_cnt_q <= fifo_cnt_q - FC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3)
			fifo_mem[wr_ptr_q] <= push_word;
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic [RECIP_W+AREA_W-1:0] recip_chk;

	assign recip_chk = (RECIP_W+AREA_W)'(recip_q) * (RECIP_W+AREA_W)'(area_q);

	// The credit check must keep a result from reaching a full queue.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((fifo_cnt_q < FC_W'(FIFO_DEPTH)) || pop))
		else $error("result pushed into a full output queue");

	// Once the divider is idle it holds the rounded-up reciprocal of the area.
	a_recip_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(!div_go_q && !div_busy_q) |->
		((recip_chk >= ((RECIP_W+AREA_W)'(1) << SHIFT)) &&
		((recip_chk - ((RECIP_W+AREA_W)'(1) << SHIFT)) < (RECIP_W+AREA_W)'(area_q))))
		else $error("reciprocal does not match block area");

	// Position inside the block stays below the clamped factors.
	a_block_pos: assert property (@(posedge clk) disable iff (!arst_n)
		((FB+1)'(cib_q) < (FB+1)'(bw_eff)) && ((FB+1)'(rib_q) < (FB+1)'(bh_eff)))
		else $error("position inside block out of range");

endmodule

[tb/box_average_downscaler_test.sv]
module box_average_downscaler_test;
	import bxd_pkg::*;

	// Register indexes past the end of the register list. Writes to them must be ignored
	// and must not restart the frame.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_FACTOR   = 16;
	localparam int STORE_BITS   = 16;
	// Cycles to let pass after the last expected item before a register write. Pixels that
	// make no output item may still be in the three-stage pipeline at that point.
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1000000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	pixel_ch pixel_if ();
	mean_ch  mean_if ();

	box_average_downscaler #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (pixel_if),
		.mean        (mean_if)
	);

	// The testbench's own copy of the block state. The configuration registers hold the raw
	// written values; clamping to the legal ranges is done when a pixel is predicted, just
	// as the block is expected to do it.
	logic [SIZE_W-1:0]     reg_image_width  = RST_IMAGE_WIDTH;
	logic [SIZE_W-1:0]     reg_image_height = RST_IMAGE_HEIGHT;
	logic [FACTOR_W-1:0]   reg_block_width  = RST_BLOCK_WIDTH;
	logic [FACTOR_W-1:0]   reg_block_height = RST_BLOCK_HEIGHT;
	logic [STORE_BITS-1:0] column_sums [MAX_WIDTH][CHANNELS];
	int unsigned           raster_column    = 0;
	int unsigned           raster_row       = 0;
	int unsigned           column_in_block  = 0;
	int unsigned           row_in_block     = 0;
	int unsigned           block_column     = 0;

	mean_t expected_means[$];
	int    error_count = 0;

	// Idle percentages for the pixel sender and the mean receiver, and a hold-off that
	// the receiver counts down on its own.
	int unsigned sender_idle_pct   = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned receiver_hold     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or an item that never shows up ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("box_average_downscaler_test: done, errors");
		$finish;
	end

	function automatic int unsigned clamp_setting(int unsigned value, int unsigned limit);
		if (value == 0)
			return 1;
		if (value > limit)
			return limit;
		return value;
	endfunction

	function automatic void restart_frame();
		raster_column   = 0;
		raster_row      = 0;
		column_in_block = 0;
		row_in_block    = 0;
		block_column    = 0;
	endfunction

	// Updates the model state for one accepted pixel and queues the output item that the
	// pixel completes, if it is the bottom-right pixel of a block inside the reduced image.
	function automatic void predict_block_mean(pixel_t px);
		int unsigned      width, height, bw, bh, out_width, out_height, col, row, sum, area;
		logic [PIX_W-1:0] level [CHANNELS];
		logic [PIX_W-1:0] mean_level [CHANNELS];
		bit               first;
		mean_t            m;

		width      = clamp_setting(reg_image_width, MAX_WIDTH);
		height     = clamp_setting(reg_image_height, ROW_LIMIT);
		bw         = clamp_setting(reg_block_width, MAX_FACTOR);
		bh         = clamp_setting(reg_block_height, MAX_FACTOR);
		out_width  = width / bw;
		out_height = height / bh;
		col        = block_column;
		row        = raster_row / bh;
		level[0]   = px.pixel_red;
		level[1]   = px.pixel_green;
		level[2]   = px.pixel_blue;
		level[3]   = px.pixel_alpha;

		// Pixels in leftover columns or rows touch nothing.
		if (col < out_width && row < out_height) begin
			first = (column_in_block == 0) && (row_in_block == 0);
			for (int c = 0; c < CHANNELS; c++) begin
				sum = first ? level[c] : column_sums[col][c] + level[c];
				column_sums[col][c] = sum[STORE_BITS-1:0];
			end
			if (column_in_block == bw - 1 && row_in_block == bh - 1) begin
				area = bw * bh;
				for (int c = 0; c < CHANNELS; c++)
					mean_level[c] = PIX_W'(column_sums[col][c] / area);
				m.mean_red   = mean_level[0];
				m.mean_green = mean_level[1];
				m.mean_blue  = mean_level[2];
				m.mean_alpha = mean_level[3];
				m.out_column = COORD_W'(col);
				m.out_row    = COORD_W'(row);
				m.frame_done = (col == out_width - 1) && (row == out_height - 1);
				expected_means = {expected_means, m};
			end
		end

		// Step the raster position; the frame wraps after the last row.
		raster_column++;
		column_in_block++;
		if (column_in_block >= bw) begin
			column_in_block = 0;
			block_column++;
		end
		if (raster_column >= width) begin
			raster_column   = 0;
			column_in_block = 0;
			block_column    = 0;
			raster_row++;
			row_in_block++;
			if (row_in_block >= bh)
				row_in_block = 0;
			if (raster_row >= height) begin
				raster_row   = 0;
				row_in_block = 0;
			end
		end
	endfunction

	function automatic pixel_t make_pixel(int r, int g, int b, int a);
		pixel_t px;

		px.pixel_red   = PIX_W'(r);
		px.pixel_green = PIX_W'(g);
		px.pixel_blue  = PIX_W'(b);
		px.pixel_alpha = PIX_W'(a);
		return px;
	endfunction

	// Full-scale and zero levels come up often enough to hit the saturated and empty
	// block means; the rest is uniform.
	function automatic logic [PIX_W-1:0] random_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
		sender_idle_pct   = sender_pct;
		receiver_idle_pct = receiver_pct;
	endtask

	// Called at a falling edge; returns at the falling edge after the item was accepted,
	// with valid still high so that a following item can go out without a gap.
	task automatic send_pixel(pixel_t px);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			pixel_if.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_if.valid <= 1'b1;
		pixel_if.data  <= px;
		do
			@(posedge clk);
		while (!pixel_if.ready);
		predict_block_mean(px);
		@(negedge clk);
	endtask

	task automatic end_burst();
		pixel_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_random_pixels(int n);
		repeat (n)
			send_pixel(make_pixel(random_level(), random_level(), random_level(),
				random_level()));
	endtask

	task automatic send_flat_pixels(int n, int level);
		repeat (n)
			send_pixel(make_pixel(level, level, level, level));
	endtask

	// The block is idle once every expected item has come out and the pipeline has had
	// time to drop any pixels that produce nothing.
	task automatic wait_for_idle();
		end_burst();
		while (expected_means.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		wait_for_idle();
		cfg_write_en <= 1'b1;
		cfg_index    <= index;
		cfg_data     <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (index)
			REG_IMAGE_WIDTH: begin
				reg_image_width = value[SIZE_W-1:0];
				restart_frame();
			end
			REG_IMAGE_HEIGHT: begin
				reg_image_height = value[SIZE_W-1:0];
				restart_frame();
			end
			REG_BLOCK_WIDTH: begin
				reg_block_width = value[FACTOR_W-1:0];
				restart_frame();
			end
			REG_BLOCK_HEIGHT: begin
				reg_block_height = value[FACTOR_W-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endtask

	task automatic configure(int width, int height, int bw, int bh);
		write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
		write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
		write_register(REG_BLOCK_WIDTH, CFG_DATA_W'(bw));
		write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(bh));
	endtask

	// The reset configuration is 640 by 480 with 2 by 2 blocks. Nothing comes out during
	// the first row; the start of the second row completes the first output items.
	task automatic test_reset_configuration();
		send_random_pixels(640 + 40);
	endtask

	// Hand-picked blocks with known means: saturation, truncation, single-pixel blocks,
	// zero factors and sizes, and blocks larger than the image.
	task automatic test_directed_means();
		configure(4, 2, 2, 2);
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(3, 1, 255, 0));
		send_pixel(make_pixel(0, 2, 255, 0));
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(0, 3, 255, 0));
		send_pixel(make_pixel(0, 4, 254, 0));

		// One-pixel frames pass each pixel straight through with frame_done set.
		configure(1, 1, 1, 1);
		send_pixel(make_pixel(0, 0, 0, 0));
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA));
		send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55));

		// A factor of zero acts as one.
		configure(2, 1, 0, 0);
		send_random_pixels(2);

		// A size of zero acts as one.
		configure(0, 0, 1, 1);
		send_random_pixels(2);

		// Blocks larger than the image leave an empty reduced image: nothing comes out.
		configure(3, 3, 4, 4);
		send_random_pixels(9);
	endtask

	// The largest block sums 256 full-scale pixels, the top of the row-sum range. Factors
	// above the maximum then act as the maximum, once across a row and once down a column.
	task automatic test_largest_block();
		configure(16, 16, 16, 16);
		send_flat_pixels(256, 255);
		configure(16, 1, 31, 0);
		send_random_pixels(16);
		configure(1, 16, 0, 17);
		send_random_pixels(16);
	endtask

	// A 5 by 5 frame with 2 by 2 blocks drops its last column and row. Frames wrap, a
	// write to an unused index leaves the frame running, and a real write restarts it.
	task automatic test_leftover_and_restart();
		configure(5, 5, 2, 2);
		send_random_pixels(2 * 25 + 7);
		write_register(REG_SPARE_FIRST, '1);
		write_register(REG_SPARE_LAST, '0);
		send_random_pixels(18);
		send_random_pixels(7);
		write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
		send_random_pixels(25);
	endtask

	function automatic int unsigned random_factor();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(5, MAX_FACTOR) : $urandom_range(1, 4);
	endfunction

	// Mostly well-formed frames with random geometry: sizes that hold a few blocks plus
	// some leftover pixels, one to three frames each but at most 120 pixels, and often a partial frame cut off
	// by the next register write. Now and then a fully random configuration adds noise,
	// including oversized and out-of-range values; those pixels are not counted.
	task automatic test_random_frames(int budget);
		int                    sent, n, bw, bh, width, height, frame_pixels, start;
		logic [CFG_DATA_W-1:0] value;

		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 7) == 0) begin
				start = $urandom_range(0, 3);
				for (int k = 0; k < 4; k++)
					write_register(CFG_INDEX_W'((start + k) % 4), CFG_DATA_W'($urandom));
				send_random_pixels($urandom_range(5, 40));
			end else begin
				bw           = random_factor();
				bh           = random_factor();
				width        = bw * $urandom_range(1, bw > 4 ? 2 : 4) + $urandom_range(0, bw - 1);
				height       = bh * $urandom_range(1, bh > 4 ? 2 : 4) + $urandom_range(0, bh - 1);
				frame_pixels = width * height;
				n = frame_pixels * $urandom_range(1, 3) + $urandom_range(0, frame_pixels - 1);
				if (n > 120)
					n = 120;
				// Registers go in a rotated order; factor writes carry junk in the bits
				// above the register width.
				start = $urandom_range(0, 3);
				for (int k = 0; k < 4; k++) begin
					case ((start + k) % 4)
						0: write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
						1: write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
						2: begin
							value = {7'($urandom), 5'(bw)};
							write_register(REG_BLOCK_WIDTH, value);
						end
						default: begin
							value = {7'($urandom), 5'(bh)};
							write_register(REG_BLOCK_HEIGHT, value);
						end
					endcase
				end
				send_random_pixels(n);
				sent += n;
			end
		end
	endtask

	// Every pixel makes an output item here, so a long receiver hold-off fills the output
	// queue and the block must stall its pixel input without losing or repeating anything.
	task automatic test_output_backpressure();
		configure(8, 8, 1, 1);
		receiver_hold = 300;
		send_random_pixels(64);
		send_random_pixels(64);
	endtask

	// The receiver drives ready at falling edges: either the long hold-off, counted here,
	// or random idling at the current percentage.
	initial begin
		forever begin
			@(negedge clk);
			if (receiver_hold != 0) begin
				receiver_hold--;
				mean_if.ready <= 1'b0;
			end else begin
				mean_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
			end
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Each accepted output item is compared against the oldest prediction.
	always @(posedge clk) begin
		mean_t want;

		if (arst_n && mean_if.valid && mean_if.ready) begin
			if (expected_means.size() == 0) begin
				$error("output item with no prediction waiting: %p", mean_if.data);
				error_count++;
			end else begin
				want = expected_means.pop_front();
				check_field("mean_red", want.mean_red, mean_if.data.mean_red);
				check_field("mean_green", want.mean_green, mean_if.data.mean_green);
				check_field("mean_blue", want.mean_blue, mean_if.data.mean_blue);
				check_field("mean_alpha", want.mean_alpha, mean_if.data.mean_alpha);
				check_field("out_column", want.out_column, mean_if.data.out_column);
				check_field("out_row", want.out_row, mean_if.data.out_row);
				check_field("frame_done", want.frame_done, mean_if.data.frame_done);
			end
		end
	end

	// Test sequence. Idling runs in three stretches: a slow receiver, then a slow sender,
	// then no idling at all.
	initial begin
		arst_n         = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		pixel_if.valid = 1'b0;
		pixel_if.data  = '0;
		mean_if.ready  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(38, 63);
		test_reset_configuration();
		test_directed_means();
		test_largest_block();
		test_leftover_and_restart();
		test_random_frames(200);

		set_idling(63, 38);
		test_random_frames(200);

		set_idling(0, 0);
		test_random_frames(200);
		test_output_backpressure();

		end_burst();
		while (expected_means.size() != 0)
			@(negedge clk);
		// Anything still coming out after this is an item nobody predicted.
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("box_average_downscaler_test: done, clean");
		else
			$display("box_average_downscaler_test: done, errors");
		$finish;
	end

endmodule
